// ----- design/wmhp_pkg.sv -----
// ---------------------------------------------------------------------------
// wmhp_pkg: shared types, constants and helpers of the 802.11 header parser
// Holds the frame state record, the input stage record and the header length
// function that both the accumulator and the summary logic use.
// ---------------------------------------------------------------------------
package wmhp_pkg;

	localparam int MAX_FRAME_BYTES = 4096;
	localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
	localparam int PLEN_W          = 12;
	localparam int CALC_W          = (CNT_W > PLEN_W) ? CNT_W : PLEN_W;
	localparam int HL_W            = 6;
	localparam int MFL_W           = 7;

	localparam logic [MFL_W-1:0] MIN_LEN_RESET = 7'd24;
	localparam logic [HL_W-1:0]  HDR_BASE      = 6'd24;
	localparam logic [HL_W-1:0]  HDR_ADDR4_ADD = 6'd6;
	localparam logic [HL_W-1:0]  HDR_QOS_ADD   = 6'd2;
	localparam logic [HL_W-1:0]  PROT_SKIP     = 6'd4;
	localparam int               PROT_TRIM     = 8;
	localparam int               ADDR4_MIN_LEN = 30;
	localparam int               ADDR4_FIRST   = 24;
	localparam int               ADDR1_FIRST   = 4;
	localparam int               ADDR_BYTES    = 6;
	localparam int               HEAD_BYTES    = 4;

	localparam logic [1:0] TYPE_DATA   = 2'd2;
	localparam logic [3:0] SUBTYPE_QOS = 4'd8;
	localparam logic [1:0] DS_BOTH     = 2'b11;

	localparam logic [7:0] ETH_EAPOL_HI = 8'h88;
	localparam logic [7:0] ETH_EAPOL_LO = 8'h8E;
	localparam logic [7:0] EAP_VERSION  = 8'h01;
	localparam logic [7:0] EAP_PACKET   = 8'h00;

	typedef struct packed {
		logic [CNT_W-1:0]   count;
		logic [15:0]        fc;
		logic [3:0][47:0]   addr;
		logic [31:0]        head;
		logic               overlong;
	} frame_t;

	typedef struct packed {
		logic       valid;
		logic       last;
		logic [7:0] data;
	} s1_t;

	function automatic logic [HL_W-1:0] hdr_len(input logic [15:0] fc);
		logic [HL_W-1:0] hl;
		hl = HDR_BASE;
		if (fc[9:8] == DS_BOTH) begin
			hl = hl + HDR_ADDR4_ADD;
		end
		if (fc[3:2] == TYPE_DATA && fc[7:4] == SUBTYPE_QOS) begin
			hl = hl + HDR_QOS_ADD;
		end
		return hl;
	endfunction

endpackage

// ----- design/wlan_mac_header_parser.sv -----
// ---------------------------------------------------------------------------
// wlan_mac_header_parser: 802.11 MAC header parser
// Takes a frame one byte per request and returns one summary per frame.
//
//   channel   direction  handshake                 payload
//   in        sink       in_valid / in_ready       rx_byte, last_byte
//   out       source     out_valid / out_ready     frame summary fields
//   cfg       sink       cfg_valid / cfg_ready     min_frame_length
//
// One byte is taken every cycle while in_ready is high; the summary becomes
// valid once the last byte has passed the input and the result register.
// in_ready falls only while a last byte waits in the input register and
// the result register is still full and not being taken.
// Reset clears the frame state and sets the minimum length to 24.
// ---------------------------------------------------------------------------
module wlan_mac_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] frame_ctrl,
	output logic [47:0] address_one,
	output logic [47:0] address_two,
	output logic [47:0] address_three,
	output logic [47:0] address_four,
	output logic        is_qos_data,
	output logic        is_protected_data,
	output logic [5:0]  payload_offset,
	output logic [11:0] body_length,
	output logic        frame_valid,
	output logic        is_eapol,
	output logic        is_eap,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  min_frame_length
);

	wmhp_pkg::s1_t                 s1;
	wmhp_pkg::frame_t              cur;
	logic                          adv;
	logic                          load;
	logic                          out_free;
	logic [wmhp_pkg::MFL_W-1:0]    mfl_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mfl_q <= wmhp_pkg::MIN_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			mfl_q <= min_frame_length;
		end
	end

	// A last byte may only move on when the result register can take it.
	assign adv  = s1.valid && (!s1.last || out_free);
	assign load = adv && s1.last;

	wmhp_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.last_byte (last_byte),
		.adv       (adv),
		.s1        (s1)
	);

	wmhp_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.s1     (s1),
		.cur    (cur)
	);

	wmhp_result u_result (
		.clk               (clk),
		.arst_n            (arst_n),
		.load              (load),
		.cur               (cur),
		.mfl               (mfl_q),
		.out_ready         (out_ready),
		.out_free          (out_free),
		.out_valid         (out_valid),
		.frame_ctrl        (frame_ctrl),
		.address_one       (address_one),
		.address_two       (address_two),
		.address_three     (address_three),
		.address_four      (address_four),
		.is_qos_data       (is_qos_data),
		.is_protected_data (is_protected_data),
		.payload_offset    (payload_offset),
		.body_length       (body_length),
		.frame_valid       (frame_valid),
		.is_eapol          (is_eapol),
		.is_eap            (is_eap)
	);

`ifndef SYNTHESIS
	a_eap_needs_eapol: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_eap |-> is_eapol)
		else $error("EAP flagged without EAPOL");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_valid |-> payload_offset == 6'd0 && body_length == 12'd0)
		else $error("invalid frame carries payload bounds");

	a_valid_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_valid |-> payload_offset >= 6'd24)
		else $error("payload offset below base header length");

	a_stall_last: assert property (@(posedge clk) disable iff (!arst_n)
		s1.valid && s1.last && out_valid && !out_ready |-> !in_ready && !adv)
		else $error("last byte advanced into a full result register");

	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid)
		else $error("frame summary lost");
`endif

endmodule

// ----- design/wmhp_in_reg.sv -----
// ---------------------------------------------------------------------------
// wmhp_in_reg: input register of the header parser
// Captures one byte request and holds it until the accumulator takes it.
// ---------------------------------------------------------------------------
module wmhp_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      rx_byte,
	input  logic            last_byte,
	input  logic            adv,
	output wmhp_pkg::s1_t   s1
);

	logic       valid_s1;
	logic       last_s1;
	logic [7:0] byte_s1;

	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
			last_s1 <= last_byte;
		end
	end

	assign s1.valid = valid_s1;
	assign s1.last  = last_s1;
	assign s1.data  = byte_s1;

endmodule

// ----- design/wmhp_accum.sv -----
// ---------------------------------------------------------------------------
// wmhp_accum: per-frame state of the header parser
// Counts bytes and drops each header byte into its field. The updated view,
// with the current byte applied, feeds the summary logic.
// ---------------------------------------------------------------------------
module wmhp_accum (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  wmhp_pkg::s1_t     s1,
	output wmhp_pkg::frame_t  cur
);

	wmhp_pkg::frame_t                st_q;
	wmhp_pkg::frame_t                nxt;
	logic [wmhp_pkg::CNT_W-1:0]      pos;
	logic [wmhp_pkg::HL_W-1:0]       hl;

	assign pos = st_q.count;
	assign hl  = wmhp_pkg::hdr_len(st_q.fc);

	always_comb begin
		nxt = st_q;
		if (pos >= wmhp_pkg::CNT_W'(wmhp_pkg::MAX_FRAME_BYTES)) begin
			nxt.overlong = 1'b1;
		end else begin
			nxt.count = pos + 1'b1;
			if (pos == '0) begin
				nxt.fc[7:0] = s1.data;
			end else if (pos == wmhp_pkg::CNT_W'(1)) begin
				nxt.fc[15:8] = s1.data;
			end else begin
				for (int a = 0; a < 3; a++) begin
					for (int k = 0; k < wmhp_pkg::ADDR_BYTES; k++) begin
						if (pos == wmhp_pkg::CNT_W'(wmhp_pkg::ADDR1_FIRST
								+ wmhp_pkg::ADDR_BYTES * a + k)) begin
							nxt.addr[a][8*(wmhp_pkg::ADDR_BYTES-1-k) +: 8] = s1.data;
						end
					end
				end
				for (int k = 0; k < wmhp_pkg::ADDR_BYTES; k++) begin
					if (pos == wmhp_pkg::CNT_W'(wmhp_pkg::ADDR4_FIRST + k)) begin
						nxt.addr[3][8*(wmhp_pkg::ADDR_BYTES-1-k) +: 8] = s1.data;
					end
				end
				// The header length is known here since both control bytes are in.
				for (int k = 0; k < wmhp_pkg::HEAD_BYTES; k++) begin
					if (pos == wmhp_pkg::CNT_W'(hl) + wmhp_pkg::CNT_W'(k)) begin
						nxt.head[8*(wmhp_pkg::HEAD_BYTES-1-k) +: 8] = s1.data;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= s1.last ? '0 : nxt;
		end
	end

	assign cur = nxt;

endmodule

// ----- design/wmhp_result.sv -----
// ---------------------------------------------------------------------------
// wmhp_result: frame summary and result register of the header parser
// Derives header length, payload bounds and EAPOL flags from the final frame
// state and holds the summary until the downstream side takes it.
// ---------------------------------------------------------------------------
module wmhp_result (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         load,
	input  wmhp_pkg::frame_t             cur,
	input  logic [wmhp_pkg::MFL_W-1:0]   mfl,
	input  logic                         out_ready,
	output logic                         out_free,
	output logic                         out_valid,
	output logic [15:0]                  frame_ctrl,
	output logic [47:0]                  address_one,
	output logic [47:0]                  address_two,
	output logic [47:0]                  address_three,
	output logic [47:0]                  address_four,
	output logic                         is_qos_data,
	output logic                         is_protected_data,
	output logic [5:0]                   payload_offset,
	output logic [11:0]                  body_length,
	output logic                         frame_valid,
	output logic                         is_eapol,
	output logic                         is_eap
);

	logic [wmhp_pkg::CALC_W-1:0]  len;
	logic [wmhp_pkg::CALC_W-1:0]  hl_w;
	logic [wmhp_pkg::CALC_W-1:0]  mfl_w;
	logic [wmhp_pkg::CALC_W-1:0]  diff;
	logic [wmhp_pkg::CALC_W-1:0]  plen_raw;
	logic [wmhp_pkg::HL_W-1:0]    hl;
	logic                         data;
	logic                         len_ok;
	logic                         valid;
	logic                         trim;
	logic                         qos;
	logic                         prot;
	logic                         eapol;
	logic                         eap;
	logic                         addr4_ok;
	logic [5:0]                   poff;
	logic [11:0]                  plen;
	logic                         out_valid_q;

	assign len    = wmhp_pkg::CALC_W'(cur.count);
	assign hl     = wmhp_pkg::hdr_len(cur.fc);
	assign hl_w   = wmhp_pkg::CALC_W'(hl);
	assign mfl_w  = wmhp_pkg::CALC_W'(mfl);
	assign data   = cur.fc[3:2] == wmhp_pkg::TYPE_DATA;
	assign len_ok = len >= mfl_w;
	assign qos    = len_ok && data && cur.fc[7:4] == wmhp_pkg::SUBTYPE_QOS;
	assign prot   = len_ok && data && cur.fc[14];
	assign valid  = len_ok && (hl_w < len) && !cur.overlong;

	assign diff     = len - hl_w;
	assign trim     = cur.fc[14] && diff >= wmhp_pkg::CALC_W'(wmhp_pkg::PROT_TRIM);
	assign plen_raw = trim ? diff - wmhp_pkg::CALC_W'(wmhp_pkg::PROT_TRIM) : diff;
	assign plen     = !valid ? 12'd0 :
		(plen_raw > wmhp_pkg::CALC_W'(12'hFFF)) ? 12'hFFF : plen_raw[11:0];
	assign poff     = !valid ? 6'd0 : (trim ? hl + wmhp_pkg::PROT_SKIP : hl);

	assign eapol = len_ok && !cur.overlong && data
		&& len >= mfl_w + wmhp_pkg::CALC_W'(wmhp_pkg::PROT_TRIM)
		&& hl_w + wmhp_pkg::CALC_W'(wmhp_pkg::PROT_TRIM) <= len
		&& cur.head[31:16] == {wmhp_pkg::ETH_EAPOL_HI, wmhp_pkg::ETH_EAPOL_LO};
	assign eap   = eapol
		&& cur.head[15:0] == {wmhp_pkg::EAP_VERSION, wmhp_pkg::EAP_PACKET};

	assign addr4_ok = len_ok && cur.fc[9:8] == wmhp_pkg::DS_BOTH
		&& len >= wmhp_pkg::CALC_W'(wmhp_pkg::ADDR4_MIN_LEN);

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_ctrl        <= cur.fc;
			address_one       <= cur.addr[0];
			address_two       <= cur.addr[1];
			address_three     <= cur.addr[2];
			address_four      <= addr4_ok ? cur.addr[3] : 48'd0;
			is_qos_data       <= qos;
			is_protected_data <= prot;
			payload_offset    <= poff;
			body_length       <= plen;
			frame_valid       <= valid;
			is_eapol          <= eapol;
			is_eap            <= eap;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- tb/sv/wlan_mac_header_parser_test.sv -----
// ---------------------------------------------------------------------------
// wlan_mac_header_parser_test: self-checking bench for the 802.11 header parser
// Streams whole frames into the parser one byte per request and predicts the
// summary of every frame with a behavioral copy of the parser state. Covers
// directed header shapes, minimum-length settings at both extremes, output
// back-pressure and long runs of random frames with random idle cycles.
// ---------------------------------------------------------------------------
module wlan_mac_header_parser_test;

	localparam int STUCK_LIMIT  = 2000;
	localparam int IDLE_PCT     = 17;
	localparam int DRAIN_WAIT   = 4;
	localparam int RANDOM_BYTES = 80;

	typedef enum {PL_RANDOM, PL_EAPOL, PL_EAP, PL_EAPOL_NOT_EAP, PL_ZEROS, PL_ONES}
		payload_kind_t;

	typedef struct {
		logic [15:0] frame_ctrl;
		logic [47:0] address_one;
		logic [47:0] address_two;
		logic [47:0] address_three;
		logic [47:0] address_four;
		logic        is_qos_data;
		logic        is_protected_data;
		logic [5:0]  payload_offset;
		logic [11:0] body_length;
		logic        frame_valid;
		logic        is_eapol;
		logic        is_eap;
	} frame_summary_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] frame_ctrl;
	logic [47:0] address_one;
	logic [47:0] address_two;
	logic [47:0] address_three;
	logic [47:0] address_four;
	logic        is_qos_data;
	logic        is_protected_data;
	logic [5:0]  payload_offset;
	logic [11:0] body_length;
	logic        frame_valid;
	logic        is_eapol;
	logic        is_eap;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [6:0]  min_frame_length;

	// Predicted parser state, updated on every accepted byte.
	int unsigned    rx_count;
	logic [15:0]    rx_fc;
	logic [47:0]    rx_addr [4];
	logic [31:0]    rx_head;
	logic           rx_overlong;
	logic [6:0]     min_len;
	frame_summary_t summary_q [$];
	frame_summary_t want;

	int  frames_sent;
	int  bytes_sent;
	int  summaries_checked;
	int  settings_used;
	int  mismatches;
	int  stuck_cycles;
	int  rx_hold;
	bit  no_gaps;

	wlan_mac_header_parser u_top (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned header_bytes(logic [15:0] fc);
		int unsigned n;
		n = 24;
		if (fc[9:8] == wmhp_pkg::DS_BOTH) begin
			n += 6;
		end
		if (fc[3:2] == wmhp_pkg::TYPE_DATA && fc[7:4] == wmhp_pkg::SUBTYPE_QOS) begin
			n += 2;
		end
		return n;
	endfunction

	// Updates the predicted state with one accepted byte and, on the last byte
	// of a frame, queues the summary the parser must return.
	task automatic absorb_byte(input logic [7:0] b, input logic last);
		int unsigned    p, hl, len, plen, poff;
		logic           len_ok, data, valid;
		frame_summary_t s;
		if (rx_count >= wmhp_pkg::MAX_FRAME_BYTES) begin
			rx_overlong = 1'b1;
		end else begin
			p = rx_count;
			if (p == 0) begin
				rx_fc[7:0] = b;
			end else if (p == 1) begin
				rx_fc[15:8] = b;
			end else begin
				if (p >= 4 && p < 22) begin
					rx_addr[(p - 4) / 6][8 * (5 - (p - 4) % 6) +: 8] = b;
				end else if (p >= 24 && p < 30) begin
					rx_addr[3][8 * (29 - p) +: 8] = b;
				end
				hl = header_bytes(rx_fc);
				if (p >= hl && p < hl + 4) begin
					rx_head[8 * (3 - (p - hl)) +: 8] = b;
				end
			end
			rx_count++;
		end
		if (last) begin
			len    = rx_count;
			hl     = header_bytes(rx_fc);
			data   = rx_fc[3:2] == wmhp_pkg::TYPE_DATA;
			len_ok = len >= min_len;
			valid  = len_ok && hl < len && !rx_overlong;
			poff   = 0;
			plen   = 0;
			if (valid) begin
				poff = hl;
				plen = len - hl;
				// Protected frames lose the IV in front and the MIC/ICV behind.
				if (rx_fc[14] && plen >= 8) begin
					plen -= 8;
					poff += 4;
				end
				if (plen > 4095) begin
					plen = 4095;
				end
			end
			s.frame_ctrl        = rx_fc;
			s.address_one       = rx_addr[0];
			s.address_two       = rx_addr[1];
			s.address_three     = rx_addr[2];
			s.address_four      = (len_ok && rx_fc[9:8] == wmhp_pkg::DS_BOTH
				&& len >= wmhp_pkg::ADDR4_MIN_LEN) ? rx_addr[3] : 48'd0;
			s.is_qos_data       = len_ok && data && rx_fc[7:4] == wmhp_pkg::SUBTYPE_QOS;
			s.is_protected_data = len_ok && data && rx_fc[14];
			s.payload_offset    = poff[5:0];
			s.body_length       = plen[11:0];
			s.frame_valid       = valid;
			s.is_eapol          = len_ok && !rx_overlong && data
				&& len >= int'(min_len) + 8 && hl + 8 <= len
				&& rx_head[31:16] == {wmhp_pkg::ETH_EAPOL_HI, wmhp_pkg::ETH_EAPOL_LO};
			s.is_eap            = s.is_eapol
				&& rx_head[15:0] == {wmhp_pkg::EAP_VERSION, wmhp_pkg::EAP_PACKET};
			summary_q.push_back(s);
			rx_count    = 0;
			rx_fc       = '0;
			rx_addr     = '{default: '0};
			rx_head     = '0;
			rx_overlong = 1'b0;
		end
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (!no_gaps) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid  <= 1'b1;
		rx_byte   <= b;
		last_byte <= last;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		absorb_byte(b, last);
	endtask

	task automatic send_frame(input logic [15:0] fc, input int len, input payload_kind_t kind);
		int unsigned hl;
		logic [7:0]  b;
		bit          ethertype;
		hl        = header_bytes(fc);
		ethertype = kind == PL_EAPOL || kind == PL_EAP || kind == PL_EAPOL_NOT_EAP;
		for (int i = 0; i < len; i++) begin
			case (kind)
				PL_ZEROS: b = 8'h00;
				PL_ONES:  b = 8'hFF;
				default:  b = 8'($urandom_range(255));
			endcase
			if (i == 0) begin
				b = fc[7:0];
			end else if (i == 1) begin
				b = fc[15:8];
			end else if (ethertype) begin
				if (i == hl) begin
					b = wmhp_pkg::ETH_EAPOL_HI;
				end else if (i == hl + 1) begin
					b = wmhp_pkg::ETH_EAPOL_LO;
				end else if (i == hl + 2 && kind != PL_EAPOL) begin
					b = wmhp_pkg::EAP_VERSION;
				end else if (i == hl + 3 && kind == PL_EAP) begin
					b = wmhp_pkg::EAP_PACKET;
				end else if (i == hl + 3 && kind == PL_EAPOL_NOT_EAP) begin
					b = 8'($urandom_range(255, 1));
				end
			end
			send_byte(b, i == len - 1);
		end
		frames_sent++;
	endtask

	// Stops offering bytes until every predicted summary has come back.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (summary_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_min_len(input logic [6:0] v);
		cfg_valid        <= 1'b1;
		min_frame_length <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		min_len = v;
		settings_used++;
	endtask

	function automatic logic [15:0] random_fc();
		logic [15:0] fc;
		fc = 16'($urandom_range(16'hFFFF));
		// Mostly plausible data frames and frames of random type, some raw noise.
		if ($urandom_range(99) >= 15) begin
			if ($urandom_range(99) < 55) begin
				fc[3:2] = wmhp_pkg::TYPE_DATA;
				if ($urandom_range(1)) begin
					fc[7:4] = wmhp_pkg::SUBTYPE_QOS;
				end
			end
			fc[9:8] = ($urandom_range(99) < 30) ? wmhp_pkg::DS_BOTH : 2'(fc[9:8] & 2'b01);
			fc[14]  = $urandom_range(99) < 35;
		end
		return fc;
	endfunction

	function automatic int random_len(input int unsigned hl);
		int r;
		r = $urandom_range(99);
		if (r < 10) begin
			return int'($urandom_range(23, 1));
		end else if (r < 80) begin
			return int'($urandom_range(hl + 16, hl - 2));
		end else if (r < 95) begin
			return int'($urandom_range(100, 60));
		end
		return int'($urandom_range(160, 101));
	endfunction

	task automatic test_directed_frames();
		send_frame(16'h0000, 24, PL_RANDOM);
		send_frame(16'h0080, 25, PL_RANDOM);
		send_frame(16'h0308, 30, PL_RANDOM);
		send_frame(16'h0388, 40, PL_EAPOL);
		send_frame(16'h0088, 27, PL_EAP);
		send_frame(16'h4008, 30, PL_RANDOM);
		send_frame(16'h4388, 40, PL_EAP);
		send_frame(16'h0008, 32, PL_EAP);
		send_frame(16'h0008, 31, PL_EAP);
		send_frame(16'h0000, 1, PL_RANDOM);
		send_frame(16'h0008, 10, PL_RANDOM);
		wait_idle();
	endtask

	task automatic test_min_length_extremes();
		write_min_len(7'd0);
		send_frame(16'h0088, 1, PL_RANDOM);
		send_frame(16'h4008, 2, PL_RANDOM);
		send_frame(16'h0008, 8, PL_EAPOL);
		send_frame(16'h0008, 32, PL_EAP);
		wait_idle();
		write_min_len(7'd127);
		send_frame(16'h0008, 40, PL_EAP);
		wait_idle();
	endtask

	task automatic test_output_stall();
		write_min_len(wmhp_pkg::MIN_LEN_RESET);
		rx_hold = 300;
		repeat (30) send_frame(random_fc(), int'($urandom_range(3, 1)), PL_RANDOM);
		wait_idle();
	endtask

	task automatic test_random_traffic();
		int            start_bytes, start_frames, r;
		logic [15:0]   fc;
		payload_kind_t kind;
		logic [6:0]    setting;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: setting = wmhp_pkg::MIN_LEN_RESET;
				1: setting = 7'($urandom_range(64, 24));
				2: setting = 7'($urandom_range(23, 1));
				default: setting = 7'd64;
			endcase
			write_min_len(setting);
			// One phase runs back to back on both channels.
			no_gaps      = phase == 1;
			start_bytes  = bytes_sent;
			start_frames = frames_sent;
			while (bytes_sent - start_bytes < RANDOM_BYTES || frames_sent - start_frames < 2) begin
				fc   = random_fc();
				kind = PL_RANDOM;
				r    = $urandom_range(99);
				if (fc[3:2] == wmhp_pkg::TYPE_DATA && r < 45) begin
					kind = (r < 15) ? PL_EAPOL : (r < 35) ? PL_EAP : PL_EAPOL_NOT_EAP;
				end
				send_frame(fc, random_len(header_bytes(fc)), kind);
			end
			wait_idle();
		end
		no_gaps = 1'b0;
	endtask

	task automatic check_field(input string name, input logic [47:0] exp_val,
		input logic [47:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, act_val);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (summary_q.size() == 0) begin
				$error("frame summary returned with no frame outstanding");
				mismatches++;
			end else begin
				want = summary_q.pop_front();
				check_field("frame_ctrl", want.frame_ctrl, frame_ctrl);
				check_field("address_one", want.address_one, address_one);
				check_field("address_two", want.address_two, address_two);
				check_field("address_three", want.address_three, address_three);
				check_field("address_four", want.address_four, address_four);
				check_field("is_qos_data", want.is_qos_data, is_qos_data);
				check_field("is_protected_data", want.is_protected_data, is_protected_data);
				check_field("payload_offset", want.payload_offset, payload_offset);
				check_field("body_length", want.body_length, body_length);
				check_field("frame_valid", want.frame_valid, frame_valid);
				check_field("is_eapol", want.is_eapol, is_eapol);
				check_field("is_eap", want.is_eap, is_eap);
				summaries_checked++;
			end
		end
	end

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_gaps || $urandom_range(99) >= IDLE_PCT;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
			|| (cfg_valid && cfg_ready)) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
		end
		if (stuck_cycles >= STUCK_LIMIT) begin
			$error("no request accepted for %0d cycles", STUCK_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		rx_byte          = '0;
		last_byte        = 1'b0;
		out_ready        = 1'b0;
		cfg_valid        = 1'b0;
		min_frame_length = wmhp_pkg::MIN_LEN_RESET;
		min_len          = wmhp_pkg::MIN_LEN_RESET;
		rx_count         = 0;
		rx_fc            = '0;
		rx_addr          = '{default: '0};
		rx_head          = '0;
		rx_overlong      = 1'b0;
		rx_hold          = 0;
		no_gaps          = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_frames();
		test_min_length_extremes();
		test_output_stall();
		test_random_traffic();
		wait_idle();
		repeat (8) @(posedge clk);

		$display("Sent %0d frames (%0d bytes) and checked %0d summaries under %0d",
			frames_sent, bytes_sent, summaries_checked, settings_used);
		$display("minimum-length writes, with short, protected, EAPOL and stalled traffic.");
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
design/wmhp_pkg.sv
design/wmhp_in_reg.sv
design/wmhp_accum.sv
design/wmhp_result.sv
design/wlan_mac_header_parser.sv
tb/sv/wlan_mac_header_parser_test.sv
